@@ hdl/asc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asc_pkg
// shared types, instruction field codes and sizes of the accumulator select
// alu core
// ----------------------------------------------------------------------------
package asc_pkg;

	localparam int INSTR_W  = 16;
	localparam int DATA_W   = 64;
	localparam int RF_DEPTH = 32;
	localparam int RIDX_W   = $clog2(RF_DEPTH);
	localparam int IMM_W    = 9;
	localparam int OUTC_W   = 3;

	localparam int OPQ_DEPTH = 2;
	localparam int RSQ_DEPTH = 2;

	// instruction classes, bits 15:14
	localparam logic [1:0] CLS_BRANCH = 2'd0;
	localparam logic [1:0] CLS_IMM    = 2'd1;
	localparam logic [1:0] CLS_REG    = 2'd2;
	localparam logic [1:0] CLS_EXT    = 2'd3;

	// extended ops, bits 2:0
	localparam logic [2:0] EXT_INVERT = 3'd0;
	localparam logic [2:0] EXT_TOGGLE = 3'd1;
	localparam logic [2:0] EXT_OUTPUT = 3'd2;

	// register sub-ops, bits 8:6
	localparam logic [2:0] SUB_SELECT = 3'd0;
	localparam logic [2:0] SUB_XOR    = 3'd5;

	// immediate sub-ops, bits 10:9
	localparam logic [1:0] IMM_LOAD = 2'd0;
	localparam logic [1:0] IMM_RSVD = 2'd1;

	localparam logic [RIDX_W-1:0] IMM_REG = RIDX_W'(RF_DEPTH - 1);

	typedef enum logic [2:0] {
		ALU_ADD = 3'd1,
		ALU_SUB = 3'd2,
		ALU_AND = 3'd3,
		ALU_OR  = 3'd4,
		ALU_XOR = 3'd5
	} alu_t;

	typedef enum logic [3:0] {
		K_NOP,
		K_INVERT,
		K_TOGGLE,
		K_OUTPUT,
		K_SELECT,
		K_ALU,
		K_LOADIMM,
		K_UNIMPL,
		K_HALT_ILL,
		K_HALT_BR
	} kind_t;

	typedef enum logic [OUTC_W-1:0] {
		OUT_DONE    = 3'd0,
		OUT_VALUE   = 3'd1,
		OUT_UNIMPL  = 3'd2,
		OUT_ILLEGAL = 3'd3,
		OUT_BRANCH  = 3'd4,
		OUT_IGNORED = 3'd5
	} outcome_t;

	typedef struct packed {
		kind_t             kind;
		alu_t              alu;
		logic [RIDX_W-1:0] ridx;
		logic [IMM_W-1:0]  imm;
	} op_t;

endpackage

@@ hdl/asc_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asc_front
// accepts instruction words, decodes them into ops and holds them in a short
// op queue for the execution side
// ----------------------------------------------------------------------------
module asc_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	output logic                             full,
	input  logic [asc_pkg::INSTR_W-1:0]      instruction,
	output logic                             op_valid,
	output asc_pkg::op_t                     op_head,
	input  logic                             op_pop
);

	localparam int PW = (asc_pkg::OPQ_DEPTH > 1) ? $clog2(asc_pkg::OPQ_DEPTH) : 1;
	localparam int CW = $clog2(asc_pkg::OPQ_DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(asc_pkg::OPQ_DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(asc_pkg::OPQ_DEPTH);

	asc_pkg::op_t dec;
	asc_pkg::op_t opq_q [asc_pkg::OPQ_DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic          wr_fire, rd_fire;

	always_comb begin
		dec.kind = asc_pkg::K_NOP;
		dec.alu  = asc_pkg::ALU_ADD;
		dec.ridx = instruction[asc_pkg::RIDX_W-1:0];
		dec.imm  = instruction[asc_pkg::IMM_W-1:0];
		unique case (instruction[15:14])
			asc_pkg::CLS_EXT: begin
				unique case (instruction[2:0])
					asc_pkg::EXT_INVERT: dec.kind = asc_pkg::K_INVERT;
					asc_pkg::EXT_TOGGLE: dec.kind = asc_pkg::K_TOGGLE;
					asc_pkg::EXT_OUTPUT: dec.kind = asc_pkg::K_OUTPUT;
					default:             dec.kind = asc_pkg::K_HALT_ILL;
				endcase
			end
			asc_pkg::CLS_REG: begin
				priority if (instruction[8:6] == asc_pkg::SUB_SELECT) begin
					dec.kind = asc_pkg::K_SELECT;
				end else if (instruction[8:6] <= asc_pkg::SUB_XOR) begin
					dec.kind = asc_pkg::K_ALU;
					dec.alu  = asc_pkg::alu_t'(instruction[8:6]);
				end else begin
					dec.kind = asc_pkg::K_NOP;
				end
			end
			asc_pkg::CLS_IMM: begin
				unique case (instruction[10:9])
					asc_pkg::IMM_LOAD: dec.kind = asc_pkg::K_LOADIMM;
					asc_pkg::IMM_RSVD: dec.kind = asc_pkg::K_UNIMPL;
					default:           dec.kind = asc_pkg::K_NOP;
				endcase
			end
			default: dec.kind = asc_pkg::K_HALT_BR;
		endcase
	end

	assign full     = (cnt_q == FULL_CNT);
	assign op_valid = (cnt_q != '0);
	assign op_head  = opq_q[rd_ptr_q];
	assign wr_fire  = push && !full;
	assign rd_fire  = op_pop && op_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_fire) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_fire) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_fire && !rd_fire) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd_fire && !wr_fire) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_fire) begin
			opq_q[wr_ptr_q] <= dec;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= FULL_CNT)
		else $error("op queue count past depth");
	assert property (@(posedge clk) disable iff (!arst_n)
		(wr_fire && !rd_fire) |=> (cnt_q == $past(cnt_q) + 1'b1))
		else $error("op queue count lost a word");
	assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == FULL_CNT) |-> (wr_ptr_q == rd_ptr_q))
		else $error("op queue pointers disagree when full");

endmodule

@@ hdl/asc_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asc_back
// executes ops against the register file in two stages (read, then alu and
// write back) and queues result words for the consumer
// ----------------------------------------------------------------------------
module asc_back (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   op_valid,
	input  asc_pkg::op_t                           op_head,
	output logic                                   op_pop,
	output logic                                   empty,
	input  logic                                   pop,
	output logic [asc_pkg::OUTC_W-1:0]             outcome,
	output logic signed [asc_pkg::DATA_W-1:0]      out_value
);

	localparam int RW = asc_pkg::RIDX_W;
	localparam int DW = asc_pkg::DATA_W;
	localparam int PW = (asc_pkg::RSQ_DEPTH > 1) ? $clog2(asc_pkg::RSQ_DEPTH) : 1;
	localparam int CW = $clog2(asc_pkg::RSQ_DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(asc_pkg::RSQ_DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(asc_pkg::RSQ_DEPTH);

	// architectural state
	logic [DW-1:0]                rf_mem [asc_pkg::RF_DEPTH];
	logic [asc_pkg::RF_DEPTH-1:0] rf_vld_q;
	logic [RW-1:0]                sel_q;
	logic                         dir_q;
	logic                         halted_q;

	// stage 2
	logic                     valid_s2;
	asc_pkg::kind_t           kind_s2;
	asc_pkg::alu_t            alu_s2;
	asc_pkg::outcome_t        outcome_s2;
	logic                     we_s2;
	logic [RW-1:0]            waddr_s2;
	logic [asc_pkg::IMM_W-1:0] imm_s2;
	logic [DW-1:0]            rd_a_s2, rd_b_s2, fwd_s2;
	logic                     vld_a_s2, vld_b_s2, fwd_a_s2, fwd_b_s2;

	// result queue
	asc_pkg::outcome_t rq_oc_q  [asc_pkg::RSQ_DEPTH];
	logic [DW-1:0]     rq_val_q [asc_pkg::RSQ_DEPTH];
	logic [PW-1:0]     rq_wr_q, rq_rd_q;
	logic [CW-1:0]     rq_cnt_q;

	logic              pop_fire, push_ok, out_push, adv, op_fire, wr_fire;
	logic [RW-1:0]     ra, rb;
	logic [DW-1:0]     opa, opb, res, imm_ext;
	asc_pkg::outcome_t oc_s1;
	logic              we_s1;
	logic [RW-1:0]     waddr_s1;

	assign pop_fire = pop && !empty;
	assign push_ok  = (rq_cnt_q != FULL_CNT) || pop_fire;
	assign out_push = valid_s2 && push_ok;
	assign adv      = !valid_s2 || push_ok;
	assign op_pop   = adv;
	assign op_fire  = op_valid && adv;
	assign wr_fire  = out_push && we_s2;

	assign ra = sel_q;
	assign rb = op_head.ridx;

	// read stage decode
	always_comb begin
		oc_s1    = asc_pkg::OUT_DONE;
		we_s1    = 1'b0;
		waddr_s1 = sel_q;
		if (halted_q) begin
			oc_s1 = asc_pkg::OUT_IGNORED;
		end else begin
			unique case (op_head.kind)
				asc_pkg::K_OUTPUT:   oc_s1 = asc_pkg::OUT_VALUE;
				asc_pkg::K_UNIMPL:   oc_s1 = asc_pkg::OUT_UNIMPL;
				asc_pkg::K_HALT_ILL: oc_s1 = asc_pkg::OUT_ILLEGAL;
				asc_pkg::K_HALT_BR:  oc_s1 = asc_pkg::OUT_BRANCH;
				asc_pkg::K_INVERT:   we_s1 = 1'b1;
				asc_pkg::K_ALU: begin
					we_s1 = 1'b1;
					if (dir_q) begin
						waddr_s1 = op_head.ridx;
					end
				end
				asc_pkg::K_LOADIMM: begin
					we_s1    = 1'b1;
					waddr_s1 = asc_pkg::IMM_REG;
				end
				default: oc_s1 = asc_pkg::OUT_DONE;
			endcase
		end
	end

	// register file, registered reads
	always_ff @(posedge clk) begin
		if (wr_fire) begin
			rf_mem[waddr_s2] <= res;
		end
		if (op_fire) begin
			rd_a_s2 <= rf_mem[ra];
			rd_b_s2 <= rf_mem[rb];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rf_vld_q <= '0;
			sel_q    <= '0;
			dir_q    <= 1'b0;
			halted_q <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (wr_fire) begin
				rf_vld_q[waddr_s2] <= 1'b1;
			end
			if (adv) begin
				valid_s2 <= op_valid;
			end
			if (op_fire && !halted_q) begin
				unique case (op_head.kind)
					asc_pkg::K_SELECT:   sel_q    <= op_head.ridx;
					asc_pkg::K_TOGGLE:   dir_q    <= !dir_q;
					asc_pkg::K_HALT_ILL,
					asc_pkg::K_HALT_BR:  halted_q <= 1'b1;
					default: ;
				endcase
			end
		end
	end

	// stage 2 payload, with bypass of the write that retires on the same edge
	always_ff @(posedge clk) begin
		if (op_fire) begin
			kind_s2    <= op_head.kind;
			alu_s2     <= op_head.alu;
			imm_s2     <= op_head.imm;
			outcome_s2 <= oc_s1;
			we_s2      <= we_s1;
			waddr_s2   <= waddr_s1;
			vld_a_s2   <= rf_vld_q[ra];
			vld_b_s2   <= rf_vld_q[rb];
			fwd_a_s2   <= wr_fire && (waddr_s2 == ra);
			fwd_b_s2   <= wr_fire && (waddr_s2 == rb);
			fwd_s2     <= res;
		end
	end

	assign opa = fwd_a_s2 ? fwd_s2 : (vld_a_s2 ? rd_a_s2 : '0);
	assign opb = fwd_b_s2 ? fwd_s2 : (vld_b_s2 ? rd_b_s2 : '0);
	assign imm_ext = {{(DW - asc_pkg::IMM_W){imm_s2[asc_pkg::IMM_W-1]}}, imm_s2};

	always_comb begin
		unique case (kind_s2)
			asc_pkg::K_INVERT:  res = ~opa;
			asc_pkg::K_LOADIMM: res = imm_ext;
			asc_pkg::K_ALU: begin
				unique case (alu_s2)
					asc_pkg::ALU_ADD: res = opa + opb;
					asc_pkg::ALU_SUB: res = opa - opb;
					asc_pkg::ALU_AND: res = opa & opb;
					asc_pkg::ALU_OR:  res = opa | opb;
					default:          res = opa ^ opb;
				endcase
			end
			default: res = opa;
		endcase
	end

	// result queue
	assign empty     = (rq_cnt_q == '0);
	assign outcome   = rq_oc_q[rq_rd_q];
	assign out_value = rq_val_q[rq_rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rq_wr_q  <= '0;
			rq_rd_q  <= '0;
			rq_cnt_q <= '0;
		end else begin
			if (out_push) begin
				rq_wr_q <= (rq_wr_q == LAST) ? '0 : rq_wr_q + 1'b1;
			end
			if (pop_fire) begin
				rq_rd_q <= (rq_rd_q == LAST) ? '0 : rq_rd_q + 1'b1;
			end
			if (out_push && !pop_fire) begin
				rq_cnt_q <= rq_cnt_q + 1'b1;
			end else if (pop_fire && !out_push) begin
				rq_cnt_q <= rq_cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_push) begin
			rq_oc_q[rq_wr_q]  <= outcome_s2;
			rq_val_q[rq_wr_q] <= (outcome_s2 == asc_pkg::OUT_VALUE) ? opa : '0;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) halted_q |=> halted_q)
		else $error("halt cleared without reset");
	assert property (@(posedge clk) disable iff (!arst_n)
		(op_fire && halted_q) |=> (outcome_s2 == asc_pkg::OUT_IGNORED && !we_s2))
		else $error("op acted while halted");
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && we_s2) |-> (outcome_s2 == asc_pkg::OUT_DONE))
		else $error("register write on a reporting op");
	assert property (@(posedge clk) disable iff (!arst_n) rq_cnt_q <= FULL_CNT)
		else $error("result queue overrun");

endmodule

@@ hdl/accumulator_select_alu_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// accumulator_select_alu_core
// 16-bit instruction core on 32 x 64-bit registers with a selected-register
// pointer, a direction flag and a sticky halt
// ----------------------------------------------------------------------------
// path: a pushed word passes the op queue, the register file read stage and
// the alu and write back stage, in that order, on its way to the result ports
// throughput: one instruction per cycle while the result queue has room or is
// popped; the read stage reads and the write back stage writes the register file
// reset: arst_n clears pointer, direction, halt, queues and register valid
// bits at once; registers read as zero until written, no clearing pass
// ----------------------------------------------------------------------------
module accumulator_select_alu_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	output logic                              full,
	input  logic [asc_pkg::INSTR_W-1:0]       instruction,
	output logic                              empty,
	input  logic                              pop,
	output logic [asc_pkg::OUTC_W-1:0]        outcome,
	output logic signed [asc_pkg::DATA_W-1:0] out_value
);

	logic         op_valid;
	logic         op_pop;
	asc_pkg::op_t op_head;

	asc_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.instruction (instruction),
		.op_valid    (op_valid),
		.op_head     (op_head),
		.op_pop      (op_pop)
	);

	asc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.op_valid  (op_valid),
		.op_head   (op_head),
		.op_pop    (op_pop),
		.empty     (empty),
		.pop       (pop),
		.outcome   (outcome),
		.out_value (out_value)
	);

endmodule
